// ===== sv/hlfa_pkg.sv =====
// Hole list fit allocator: shared types, constants and codes.
// Depends on nothing; imported by every module of the block.
package hlfa_pkg;

   localparam int MaxHoles = 16;
   localparam int MemWords = 1024;
   localparam int IdxW     = $clog2(MaxHoles);
   localparam int CntW     = $clog2(MaxHoles + 1);
   localparam int AddrW    = 10;
   localparam int LenW     = 11;
   localparam int EndW     = 12;

   typedef logic [IdxW-1:0]  idx_type;
   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [AddrW-1:0] addr_type;
   typedef logic [LenW-1:0]  len_type;

   localparam logic [1:0] PolFirst = 2'd0;
   localparam logic [1:0] PolNext  = 2'd1;
   localparam logic [1:0] PolWorst = 2'd2;
   localparam logic [1:0] PolBest  = 2'd3;

   localparam logic [1:0] StDone   = 2'd0;
   localparam logic [1:0] StNoFit  = 2'd1;
   localparam logic [1:0] StFull   = 2'd2;

   localparam logic FuncAlloc = 1'b0;
   localparam logic FuncFree  = 1'b1;

   localparam logic RegPolicy = 1'b0;
   localparam logic RegMemSz  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_DN,
      S_SHIFT_UP,
      S_RESULT
   } state_type;

   // table edit commands from sequencer to table
   typedef enum logic [2:0] {
      T_NONE,
      T_WRITE,
      T_COPY_DN,
      T_COPY_UP,
      T_CLEAR,
      T_INIT
   } tcmd_type;

   typedef struct packed {
      tcmd_type cmd;
      idx_type  idx;
      addr_type start;
      len_type  len;
   } tctl_type;

endpackage

// ===== sv/hlfa_table.sv =====
// Hole table: start, length and valid per entry, one read port by index.
// Depends on hlfa_pkg; under sequencer control, edited one entry per cycle or all at once on init.
module hlfa_table
   import hlfa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  tctl_type ctl,
   input  len_type  init_len,
   input  idx_type  rd_idx,
   output addr_type rd_start,
   output len_type  rd_len,
   output logic     rd_valid
);

   addr_type start_ff [MaxHoles];
   len_type  len_ff   [MaxHoles];
   logic     valid_ff [MaxHoles];

   assign rd_start = start_ff[rd_idx];
   assign rd_len   = len_ff[rd_idx];
   assign rd_valid = valid_ff[rd_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxHoles; i++) begin
            valid_ff[i] <= 1'b0;
            start_ff[i] <= '0;
            len_ff[i]   <= '0;
         end
         valid_ff[0] <= 1'b1;
         len_ff[0]   <= LenW'(MemWords);
      end else begin
         unique case (ctl.cmd)
            T_NONE: ;
            T_WRITE: begin
               start_ff[ctl.idx] <= ctl.start;
               len_ff[ctl.idx]   <= ctl.len;
               valid_ff[ctl.idx] <= 1'b1;
            end
            // entry idx takes entry idx+1
            T_COPY_DN: begin
               start_ff[ctl.idx] <= start_ff[ctl.idx + idx_type'(1)];
               len_ff[ctl.idx]   <= len_ff[ctl.idx + idx_type'(1)];
               valid_ff[ctl.idx] <= valid_ff[ctl.idx + idx_type'(1)];
            end
            // entry idx takes entry idx-1
            T_COPY_UP: begin
               start_ff[ctl.idx] <= start_ff[ctl.idx - idx_type'(1)];
               len_ff[ctl.idx]   <= len_ff[ctl.idx - idx_type'(1)];
               valid_ff[ctl.idx] <= valid_ff[ctl.idx - idx_type'(1)];
            end
            T_CLEAR: begin
               start_ff[ctl.idx] <= '0;
               len_ff[ctl.idx]   <= '0;
               valid_ff[ctl.idx] <= 1'b0;
            end
            T_INIT: begin
               for (int i = 0; i < MaxHoles; i++) begin
                  valid_ff[i] <= 1'b0;
                  start_ff[i] <= '0;
                  len_ff[i]   <= '0;
               end
               valid_ff[0] <= 1'b1;
               len_ff[0]   <= init_len;
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== sv/hole_list_fit_allocator.sv =====
// Hole list fit allocator top level: CSR port, sequencer and result register.
// Depends on hlfa_pkg and hlfa_table.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  req     | req_valid req_stall req_func req_request_size| in
//          | req_free_address                            |
//  rsp     | rsp_valid rsp_stall rsp_status              | out
//          | rsp_block_address                           |
//  csr     | psel penable pwrite paddr pwdata prdata ... | APB slave
//
// A request word scans the hole table one entry per cycle, then passes
// through a decide state and, when a hole is removed or inserted, a sweep
// that moves entries one per cycle and ends in a closing write or clear,
// then a result state that marks the result register valid. No new request
// is taken until the result word has left its register; the single table
// read port and the shared compare/adder on it serve one request at a time.
// Reset restores one hole covering MemWords, first fit, cursor zero.
// req_stall is high from acceptance until the result word leaves its register;
// rsp_stall just holds the result.
module hole_list_fit_allocator
   import hlfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [10:0] req_request_size,
   input  logic [9:0]  req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_block_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:2]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   state_type state_ff, state_in;

   logic [1:0] policy_ff;
   len_type    memsz_ff;
   idx_type    cursor_ff, cursor_in;

   // request word
   logic       func_ff;
   len_type    size_ff;
   addr_type   faddr_ff;

   // scan state
   idx_type    scan_ff, scan_in;   // scan counter k
   logic       found_ff, found_in;
   idx_type    pick_ff, pick_in;
   len_type    plen_ff, plen_in;
   addr_type   pstart_ff, pstart_in;
   logic       bad_ff, bad_in;
   logic       hb_ff, hb_in, ha_ff, ha_in;
   idx_type    below_ff, below_in, above_ff, above_in;
   len_type    alen_ff, alen_in;
   cnt_type    cnt_ff, cnt_in;     // valid entries seen
   cnt_type    pos_ff, pos_in;     // insertion point

   // shift sweep
   idx_type    sh_ff, sh_in;
   idx_type    shend_ff, shend_in;
   logic       ins_ff, ins_in;     // insert after upward sweep
   logic       sh_dn_go;           // hole removal sweep follows decide

   logic [1:0] st_ff, st_in;
   addr_type   baddr_ff, baddr_in;
   logic       rv_ff;

   tctl_type   ctl;
   idx_type    rd_idx;
   addr_type   rd_start;
   len_type    rd_len;
   logic       rd_valid;

   logic       wr_cfg;
   logic       wr_memsz;
   len_type    memsz_wr;           // saturated memory size being written
   logic       accept;

   assign pready   = 1'b1;
   assign wr_cfg   = psel & penable & pwrite;
   assign wr_memsz = wr_cfg & (paddr[2] == RegMemSz);
   assign accept   = req_valid & ~req_stall;

   // stalled from acceptance until result taken
   assign req_stall = (state_ff != S_IDLE) | rv_ff;

   assign rsp_valid         = rv_ff;
   assign rsp_status        = st_ff;
   assign rsp_block_address = baddr_ff;

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         RegPolicy: prdata = {30'd0, policy_ff};
         RegMemSz:  prdata = {21'd0, memsz_ff};
         default:   prdata = '0;
      endcase
   end

   // memory size saturates into 1..MemWords
   always_comb begin
      if (pwdata[10:0] == '0) memsz_wr = LenW'(1);
      else if (pwdata[10:0] > LenW'(MemWords)) memsz_wr = LenW'(MemWords);
      else memsz_wr = pwdata[10:0];
   end

   hlfa_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .init_len (memsz_wr),
      .rd_idx   (rd_idx),
      .rd_start (rd_start),
      .rd_len   (rd_len),
      .rd_valid (rd_valid)
   );

   // shared compare unit on the single read port
   logic [EndW-1:0] free_end, hole_end;
   logic            fits, better;
   assign free_end = EndW'(faddr_ff) + EndW'(size_ff);
   assign hole_end = EndW'(rd_start) + EndW'(rd_len);
   assign fits     = rd_valid && (rd_len >= size_ff);
   always_comb begin
      unique case (policy_ff)
         PolWorst: better = rd_len > plen_ff;
         PolBest:  better = rd_len < plen_ff;
         default:  better = 1'b0;
      endcase
   end

   always_comb begin
      rd_idx = scan_ff;
      if (state_ff == S_SCAN && func_ff == FuncAlloc && policy_ff == PolNext)
         rd_idx = cursor_ff + scan_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (accept) state_in = S_SCAN;
         S_SCAN:     if (scan_ff == idx_type'(MaxHoles - 1)) state_in = S_DECIDE;
         S_DECIDE: begin
            if (ins_in) state_in = S_SHIFT_UP;
            else if (sh_dn_go) state_in = S_SHIFT_DN;
            else state_in = S_RESULT;
         end
         S_SHIFT_DN: if (sh_ff == shend_ff) state_in = S_RESULT;
         S_SHIFT_UP: if (sh_ff == shend_ff) state_in = S_RESULT;
         S_RESULT:   if (!rv_ff || !rsp_stall) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      scan_in = scan_ff; found_in = found_ff; pick_in = pick_ff;
      plen_in = plen_ff; pstart_in = pstart_ff; bad_in = bad_ff;
      hb_in = hb_ff; ha_in = ha_ff; below_in = below_ff; above_in = above_ff;
      alen_in = alen_ff; cnt_in = cnt_ff; pos_in = pos_ff;
      sh_in = sh_ff; shend_in = shend_ff; ins_in = ins_ff;
      st_in = st_ff; baddr_in = baddr_ff; cursor_in = cursor_ff;
      sh_dn_go = 1'b0;
      ctl = '{cmd: T_NONE, idx: '0, start: '0, len: '0};
      unique case (state_ff)
         S_IDLE: begin
            scan_in = '0; found_in = 1'b0; pick_in = '0; plen_in = '0;
            pstart_in = '0; hb_in = 1'b0; ha_in = 1'b0; cnt_in = '0;
            pos_in = '0; ins_in = 1'b0; bad_in = 1'b0;
            below_in = '0; above_in = '0; alen_in = '0;
            sh_in = '0; shend_in = '0;
         end
         S_SCAN: begin
            scan_in = scan_ff + idx_type'(1);
            if (func_ff == FuncAlloc) begin
               if (fits && (!found_ff || (policy_ff != PolFirst &&
                   policy_ff != PolNext && better))) begin
                  found_in = 1'b1; pick_in = rd_idx;
                  plen_in = rd_len; pstart_in = rd_start;
               end
            end else if (rd_valid) begin
               cnt_in = cnt_ff + cnt_type'(1);
               if (rd_start < addr_type'(faddr_ff)) pos_in = cnt_ff + cnt_type'(1);
               if (EndW'(rd_start) < free_end && EndW'(faddr_ff) < hole_end)
                  bad_in = 1'b1;
               // hole below keeps its start, so hold it for the merge write
               if (hole_end == EndW'(faddr_ff)) begin
                  hb_in = 1'b1; below_in = scan_ff; plen_in = rd_len;
                  pstart_in = rd_start;
               end
               if (EndW'(rd_start) == free_end) begin
                  ha_in = 1'b1; above_in = scan_ff; alen_in = rd_len;
               end
            end
         end
         S_DECIDE: begin
            st_in = StDone; baddr_in = '0;
            sh_in = '0; shend_in = '0; // no sweep by default
            if (func_ff == FuncAlloc) begin
               if (size_ff == '0 || !found_ff) st_in = StNoFit;
               else begin
                  baddr_in = pstart_ff;
                  if (policy_ff == PolNext) cursor_in = pick_ff;
                  if (plen_ff == size_ff) begin
                     sh_in = pick_ff; shend_in = idx_type'(MaxHoles - 1);
                     sh_dn_go = 1'b1;
                  end else
                     ctl = '{cmd: T_WRITE, idx: pick_ff,
                             start: pstart_ff + addr_type'(size_ff),
                             len: plen_ff - size_ff};
               end
            end else if (size_ff == '0 || free_end > EndW'(memsz_ff) || bad_ff) begin
               st_in = StDone;
            end else if (hb_ff && ha_ff) begin
               ctl = '{cmd: T_WRITE, idx: below_ff, start: pstart_ff,
                       len: plen_ff + size_ff + alen_ff};
               sh_in = above_ff; shend_in = idx_type'(MaxHoles - 1);
               sh_dn_go = 1'b1;
            end else if (hb_ff) begin
               ctl = '{cmd: T_WRITE, idx: below_ff, start: pstart_ff,
                       len: plen_ff + size_ff};
            end else if (ha_ff) begin
               ctl = '{cmd: T_WRITE, idx: above_ff, start: faddr_ff,
                       len: alen_ff + size_ff};
            end else if (cnt_ff == cnt_type'(MaxHoles)) begin
               st_in = StFull;
            end else if (cnt_ff == pos_ff) begin
               ctl = '{cmd: T_WRITE, idx: idx_type'(pos_ff), start: faddr_ff,
                       len: size_ff};
            end else begin
               ins_in = 1'b1;
               sh_in = idx_type'(cnt_ff); shend_in = idx_type'(pos_ff);
            end
         end
         S_SHIFT_DN: begin
            if (sh_ff == shend_ff) ctl = '{cmd: T_CLEAR, idx: sh_ff,
                                           start: '0, len: '0};
            else begin
               ctl = '{cmd: T_COPY_DN, idx: sh_ff, start: '0, len: '0};
               sh_in = sh_ff + idx_type'(1);
            end
         end
         S_SHIFT_UP: begin
            if (sh_ff == shend_ff) ctl = '{cmd: T_WRITE, idx: sh_ff,
                                           start: faddr_ff, len: size_ff};
            else begin
               ctl = '{cmd: T_COPY_UP, idx: sh_ff, start: '0, len: '0};
               sh_in = sh_ff - idx_type'(1);
            end
         end
         S_RESULT: ;
         default: ;
      endcase
      // a memory size write rebuilds the table; the user must do it only while idle, the block does not enforce it
      if (wr_memsz) begin
         ctl = '{cmd: T_INIT, idx: '0, start: '0, len: '0};
         cursor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         policy_ff <= PolFirst;
         memsz_ff  <= LenW'(MemWords);
         cursor_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         if (state_ff == S_RESULT && !rv_ff) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (wr_cfg) begin
            unique case (paddr[2])
               RegPolicy: policy_ff <= pwdata[1:0];
               RegMemSz:  memsz_ff  <= memsz_wr;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         size_ff  <= req_request_size;
         faddr_ff <= req_free_address;
      end
      scan_ff <= scan_in; found_ff <= found_in; pick_ff <= pick_in;
      plen_ff <= plen_in; pstart_ff <= pstart_in; bad_ff <= bad_in;
      hb_ff <= hb_in; ha_ff <= ha_in; below_ff <= below_in; above_ff <= above_in;
      alen_ff <= alen_in; cnt_ff <= cnt_in; pos_ff <= pos_in;
      sh_ff <= sh_in; shend_ff <= shend_in; ins_ff <= ins_in;
      st_ff <= st_in; baddr_ff <= baddr_in;
   end

endmodule
